@@ sv/obb_sat_pkg.sv @@
// Shared types and constants for the oriented box separating axis test.
// Used by every module of the block; no dependencies.
`default_nettype none
package obb_sat_pkg;
  localparam int unsigned CoordBits = 20;
  localparam int unsigned AxisBits  = 16;
  localparam int unsigned AxisFrac  = AxisBits - 2;
  localparam int unsigned RBits     = 2 * AxisBits + 2;
  localparam int unsigned TaBits    = CoordBits + 1 + AxisBits + 2;
  localparam int unsigned CmpBits   = 96;
  localparam int unsigned CfgIdxBits = 3;
  localparam int unsigned CfgBits   = 60;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrBits  = 2;

  localparam logic [CfgIdxBits-1:0] RegQCenter = 3'd0;
  localparam logic [CfgIdxBits-1:0] RegQAxisU  = 3'd1;
  localparam logic [CfgIdxBits-1:0] RegQAxisV  = 3'd2;
  localparam logic [CfgIdxBits-1:0] RegQAxisW  = 3'd3;
  localparam logic [CfgIdxBits-1:0] RegQHalf   = 3'd4;

  localparam logic [3:0] AxisNone = 4'd0;

  typedef struct packed {
    logic [59:0] node_half_sizes;
    logic [47:0] node_axis_w;
    logic [47:0] node_axis_v;
    logic [47:0] node_axis_u;
    logic [59:0] node_center;
  } in_beat_t;

  typedef struct packed {
    logic [3:0] separating_axis;
    logic       overlap;
  } out_beat_t;

  typedef struct packed {
    logic signed [TaBits-1:0]  ta0, ta1, ta2;
    logic signed [TaBits-1:0]  tb0, tb1, tb2;
    logic signed [RBits-1:0]   r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic        [CoordBits-1:0] ea0, ea1, ea2, eb0, eb1, eb2;
  } proj_t;

  function automatic logic signed [AxisBits-1:0] axc(input logic [47:0] v, input int k);
    axc = v[k*AxisBits +: AxisBits];
  endfunction

  function automatic logic signed [CoordBits:0] crd(input logic [59:0] v, input int k);
    crd = {v[k*CoordBits+CoordBits-1], v[k*CoordBits +: CoordBits]};
  endfunction
endpackage
`default_nettype wire

@@ sv/obb_separating_axis_test_core.sv @@
// Top level of the oriented box overlap test; holds the query registers.
// Depends on obb_sat_pkg, obb_sat_front, obb_sat_queue, obb_sat_back.
//
// Use: write the five query box registers over cfg_we_i / cfg_idx_i /
// cfg_data_i while idle, then stream node boxes on in_valid_i / in_stall_o.
// Each node box gives one result beat on out_valid_o / out_stall_i with
// an overlap flag and the first separating axis (0 when overlapping).
// Throughput: one beat per cycle unless an output stall backs up into
// in_stall_o. From acceptance to the result register a beat passes two front
// stages forming offsets and dot products, the four-entry queue and four back
// stages of products, sums, compares and priority pick.
// The back pipeline advances only while the output register is free or being
// taken; the front advances while the queue holds at most two beats, or three
// with one leaving in the same cycle, so a stall at the output fills the
// queue and then raises in_stall_o. Reset clears every valid flag,
// the queue pointers and the query registers (all zero).
`default_nettype none
module obb_separating_axis_test_core (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [obb_sat_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [obb_sat_pkg::CfgBits-1:0]    cfg_data_i,
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire obb_sat_pkg::in_beat_t  in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output obb_sat_pkg::out_beat_t      out_data_o
);
  localparam int unsigned CW = obb_sat_pkg::QPtrBits + 1;

  logic [59:0] qc_q, qh_q;
  logic [47:0] qu_q, qv_q, qw_q;
  logic front_adv, back_adv, f_valid, b_valid, q_ne, pop;
  logic [obb_sat_pkg::QPtrBits:0] q_cnt;
  obb_sat_pkg::proj_t f_proj, q_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q <= '0; qu_q <= '0; qv_q <= '0; qw_q <= '0; qh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        obb_sat_pkg::RegQCenter: qc_q <= cfg_data_i;
        obb_sat_pkg::RegQAxisU:  qu_q <= cfg_data_i[47:0];
        obb_sat_pkg::RegQAxisV:  qv_q <= cfg_data_i[47:0];
        obb_sat_pkg::RegQAxisW:  qw_q <= cfg_data_i[47:0];
        obb_sat_pkg::RegQHalf:   qh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front holds up to two beats in flight; keep room for them in the queue
  assign front_adv = (q_cnt <= CW'(obb_sat_pkg::QDepth - 2))
                  || (pop && q_cnt <= CW'(obb_sat_pkg::QDepth - 1));
  assign in_stall_o = !front_adv;
  assign back_adv  = !out_valid_o || !out_stall_i;
  assign pop       = back_adv && q_ne;

  obb_sat_front u_front (
    .clk_i, .rst_ni, .adv_i(front_adv), .in_valid_i, .in_data_i,
    .q_center_i(qc_q), .q_u_i(qu_q), .q_v_i(qv_q), .q_w_i(qw_q), .q_half_i(qh_q),
    .valid_o(f_valid), .proj_o(f_proj)
  );

  obb_sat_queue u_queue (
    .clk_i, .rst_ni, .push_i(f_valid && front_adv), .push_data_i(f_proj),
    .pop_i(pop), .not_empty_o(q_ne), .count_o(q_cnt), .head_o(q_head)
  );

  obb_sat_back u_back (
    .clk_i, .rst_ni, .adv_i(back_adv), .valid_i(q_ne), .p_i(q_head),
    .valid_o(b_valid), .res_o(out_data_o)
  );

  assign out_valid_o = b_valid;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= CW'(obb_sat_pkg::QDepth))
    else $error("queue overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overlap |-> out_data_o.separating_axis == obb_sat_pkg::AxisNone)
    else $error("overlap with axis");
endmodule
`default_nettype wire

@@ sv/obb_sat_front.sv @@
// Front end: accepts node boxes, forms offsets and the projection terms.
// Depends on obb_sat_pkg; feeds the queue.
`default_nettype none
module obb_sat_front (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic                    in_valid_i,
  input  wire obb_sat_pkg::in_beat_t   in_data_i,
  input  wire logic [59:0]             q_center_i,
  input  wire logic [47:0]             q_u_i,
  input  wire logic [47:0]             q_v_i,
  input  wire logic [47:0]             q_w_i,
  input  wire logic [59:0]             q_half_i,
  output logic                         valid_o,
  output obb_sat_pkg::proj_t           proj_o
);
  localparam int unsigned CB = obb_sat_pkg::CoordBits;
  localparam int unsigned AB = obb_sat_pkg::AxisBits;
  localparam int unsigned TB = obb_sat_pkg::TaBits;
  localparam int unsigned RB = obb_sat_pkg::RBits;

  logic s1_q, s1_d;
  logic signed [CB+1:0] t_q [3];
  logic signed [AB-1:0] a_q [3][3];
  logic signed [AB-1:0] b_q [3][3];
  logic [CB-1:0] ea_q [3];
  logic [CB-1:0] eb_q [3];
  logic signed [TB-1:0] ta_d [3];
  logic signed [TB-1:0] tb_d [3];
  logic signed [RB-1:0] r_d [3][3];
  logic [47:0] nax [3];
  logic [47:0] qax [3];

  assign s1_d = in_valid_i;
  assign nax[0] = in_data_i.node_axis_u;
  assign nax[1] = in_data_i.node_axis_v;
  assign nax[2] = in_data_i.node_axis_w;
  assign qax[0] = q_u_i;
  assign qax[1] = q_v_i;
  assign qax[2] = q_w_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q    <= 1'b0;
      valid_o <= 1'b0;
    end else if (adv_i) begin
      s1_q    <= s1_d;
      valid_o <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int k = 0; k < 3; k++) begin
        t_q[k]  <= (CB+2)'(obb_sat_pkg::crd(q_center_i, k))
                 - (CB+2)'(obb_sat_pkg::crd(in_data_i.node_center, k));
        ea_q[k] <= in_data_i.node_half_sizes[k*CB +: CB];
        eb_q[k] <= q_half_i[k*CB +: CB];
        for (int i = 0; i < 3; i++) begin
          a_q[i][k] <= obb_sat_pkg::axc(nax[i], k);
          b_q[i][k] <= obb_sat_pkg::axc(qax[i], k);
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ta_d[i] = TB'(t_q[0] * a_q[i][0]) + TB'(t_q[1] * a_q[i][1]) + TB'(t_q[2] * a_q[i][2]);
      tb_d[i] = TB'(t_q[0] * b_q[i][0]) + TB'(t_q[1] * b_q[i][1]) + TB'(t_q[2] * b_q[i][2]);
      for (int j = 0; j < 3; j++) begin
        r_d[i][j] = RB'(a_q[i][0] * b_q[j][0]) + RB'(a_q[i][1] * b_q[j][1])
                  + RB'(a_q[i][2] * b_q[j][2]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      proj_o.ta0 <= ta_d[0]; proj_o.ta1 <= ta_d[1]; proj_o.ta2 <= ta_d[2];
      proj_o.tb0 <= tb_d[0]; proj_o.tb1 <= tb_d[1]; proj_o.tb2 <= tb_d[2];
      proj_o.r00 <= r_d[0][0]; proj_o.r01 <= r_d[0][1]; proj_o.r02 <= r_d[0][2];
      proj_o.r10 <= r_d[1][0]; proj_o.r11 <= r_d[1][1]; proj_o.r12 <= r_d[1][2];
      proj_o.r20 <= r_d[2][0]; proj_o.r21 <= r_d[2][1]; proj_o.r22 <= r_d[2][2];
      proj_o.ea0 <= ea_q[0]; proj_o.ea1 <= ea_q[1]; proj_o.ea2 <= ea_q[2];
      proj_o.eb0 <= eb_q[0]; proj_o.eb1 <= eb_q[1]; proj_o.eb2 <= eb_q[2];
    end
  end
endmodule
`default_nettype wire

@@ sv/obb_sat_queue.sv @@
// Short queue between the front end and the axis tests.
// Depends on obb_sat_pkg for the entry type and depth.
`default_nettype none
module obb_sat_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire obb_sat_pkg::proj_t push_data_i,
  input  wire logic               pop_i,
  output logic                    not_empty_o,
  output logic [obb_sat_pkg::QPtrBits:0] count_o,
  output obb_sat_pkg::proj_t      head_o
);
  localparam int unsigned PB = obb_sat_pkg::QPtrBits;
  obb_sat_pkg::proj_t mem_q [obb_sat_pkg::QDepth];
  logic [PB-1:0] wr_q, rd_q;
  logic [PB:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PB+1)'(push_i) - (PB+1)'(pop_i);
    end
  end

  assign head_o      = mem_q[rd_q];
  assign not_empty_o = cnt_q != '0;
  assign count_o     = cnt_q;
endmodule
`default_nettype wire

@@ sv/obb_sat_back.sv @@
// Back end: evaluates the fifteen axes as a pipeline and picks the first.
// Depends on obb_sat_pkg; drains the queue, drives the output register.
`default_nettype none
module obb_sat_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               adv_i,
  input  wire logic               valid_i,
  input  wire obb_sat_pkg::proj_t p_i,
  output logic                    valid_o,
  output obb_sat_pkg::out_beat_t  res_o
);
  localparam int unsigned W  = obb_sat_pkg::CmpBits;
  localparam int unsigned FR = obb_sat_pkg::AxisFrac;
  localparam int unsigned RB = obb_sat_pkg::RBits;
  localparam int unsigned TB = obb_sat_pkg::TaBits;
  localparam int unsigned CB = obb_sat_pkg::CoordBits;
  localparam int unsigned LB = TB / 2;
  localparam int unsigned HB = TB - LB;

  logic signed [TB-1:0] ta [3], tb [3];
  logic signed [RB-1:0] r [3][3];
  logic [RB-1:0] ar [3][3];
  logic [CB-1:0] ea [3], eb [3];
  logic signed [HB-1:0] th [3], tl [3];

  // stage 1: products
  logic v1_q, v2_q, v3_q;
  logic signed [W-1:0] lhs1_q [6];
  logic signed [W-1:0] t1_q [15][4];
  logic signed [RB+HB-1:0] xp_q [9][4];
  // stage 2: sums
  logic signed [W-1:0] lhs2_q [6];
  logic signed [W-1:0] rhs2_q [15];
  logic signed [W-1:0] xd2_q [9];
  // stage 3: compare
  logic [14:0] sep_q;
  logic [3:0] pick;

  function automatic logic [CB+RB-1:0] umul(input logic [CB-1:0] e, input logic [RB-1:0] m);
    umul = e * m;
  endfunction

  function automatic logic signed [RB+HB-1:0] smul(input logic signed [HB-1:0] a,
                                                   input logic signed [RB-1:0] b);
    smul = a * b;
  endfunction

  always_comb begin
    ta[0] = p_i.ta0; ta[1] = p_i.ta1; ta[2] = p_i.ta2;
    tb[0] = p_i.tb0; tb[1] = p_i.tb1; tb[2] = p_i.tb2;
    r[0][0] = p_i.r00; r[0][1] = p_i.r01; r[0][2] = p_i.r02;
    r[1][0] = p_i.r10; r[1][1] = p_i.r11; r[1][2] = p_i.r12;
    r[2][0] = p_i.r20; r[2][1] = p_i.r21; r[2][2] = p_i.r22;
    ea[0] = p_i.ea0; ea[1] = p_i.ea1; ea[2] = p_i.ea2;
    eb[0] = p_i.eb0; eb[1] = p_i.eb1; eb[2] = p_i.eb2;
    for (int i = 0; i < 3; i++) begin
      th[i] = ta[i][TB-1:LB];
      tl[i] = HB'({1'b0, ta[i][LB-1:0]});
      for (int j = 0; j < 3; j++)
        ar[i][j] = r[i][j][RB-1] ? RB'(-r[i][j]) : r[i][j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < 3; i++) begin
        lhs1_q[i]   <= W'(ta[i][TB-1] ? -ta[i] : ta[i]) <<< FR;
        t1_q[i][0]  <= W'({1'b0, ea[i]}) <<< (2 * FR);
        lhs1_q[3+i] <= W'(tb[i][TB-1] ? -tb[i] : tb[i]) <<< FR;
        t1_q[3+i][0] <= W'({1'b0, eb[i]}) <<< (2 * FR);
        for (int j = 0; j < 3; j++) begin
          t1_q[i][1+j]   <= W'(umul(eb[j], ar[i][j]));
          t1_q[3+i][1+j] <= W'(umul(ea[j], ar[j][i]));
        end
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          xp_q[3*i+j][0] <= smul(th[(i+2)%3], r[(i+1)%3][j]);
          xp_q[3*i+j][1] <= smul(tl[(i+2)%3], r[(i+1)%3][j]);
          xp_q[3*i+j][2] <= smul(th[(i+1)%3], r[(i+2)%3][j]);
          xp_q[3*i+j][3] <= smul(tl[(i+1)%3], r[(i+2)%3][j]);
          t1_q[6+3*i+j][0] <= W'(umul(ea[(i+1)%3], ar[(i+2)%3][j]));
          t1_q[6+3*i+j][1] <= W'(umul(ea[(i+2)%3], ar[(i+1)%3][j]));
          t1_q[6+3*i+j][2] <= W'(umul(eb[(j+1)%3], ar[i][(j+2)%3]));
          t1_q[6+3*i+j][3] <= W'(umul(eb[(j+2)%3], ar[i][(j+1)%3]));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int a = 0; a < 6; a++) begin
        lhs2_q[a] <= lhs1_q[a];
        rhs2_q[a] <= t1_q[a][0] + t1_q[a][1] + t1_q[a][2] + t1_q[a][3];
      end
      for (int c = 0; c < 9; c++) begin
        rhs2_q[6+c] <= (t1_q[6+c][0] + t1_q[6+c][1] + t1_q[6+c][2] + t1_q[6+c][3]) <<< FR;
        xd2_q[c] <= ((W'(xp_q[c][0]) - W'(xp_q[c][2])) <<< LB)
                  + W'(xp_q[c][1]) - W'(xp_q[c][3]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int a = 0; a < 6; a++)
        sep_q[a] <= lhs2_q[a] > rhs2_q[a];
      for (int c = 0; c < 9; c++)
        sep_q[6+c] <= (xd2_q[c] < 0 ? -xd2_q[c] : xd2_q[c]) > rhs2_q[6+c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; valid_o <= 1'b0;
    end else if (adv_i) begin
      v1_q <= valid_i; v2_q <= v1_q; v3_q <= v2_q; valid_o <= v3_q;
    end
  end

  always_comb begin
    pick = obb_sat_pkg::AxisNone;
    for (int a = 14; a >= 0; a--)
      if (sep_q[a]) pick = 4'(a + 1);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_o.overlap         <= sep_q == '0;
      res_o.separating_axis <= pick;
    end
  end
endmodule
`default_nettype wire

@@ dv/obb_sat_checker.sv @@
// Checker for the oriented box overlap test: follows the query register writes,
// predicts each node box result and compares it with the result beats.
// Depends on obb_sat_pkg.
`timescale 1ns / 100ps
module obb_sat_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [obb_sat_pkg::CfgIdxBits-1:0]   cfg_idx_i,
  input  logic [obb_sat_pkg::CfgBits-1:0]      cfg_data_i,
  input  logic                                 in_valid_i,
  input  logic                                 in_stall_i,
  input  obb_sat_pkg::in_beat_t                in_data_i,
  input  logic                                 out_valid_i,
  input  logic                                 out_stall_i,
  input  obb_sat_pkg::out_beat_t               out_data_i,
  output int                                   errors_o,
  output int                                   pending_o,
  output int                                   checked_o
);
  localparam int unsigned CB = obb_sat_pkg::CoordBits;
  localparam int unsigned AB = obb_sat_pkg::AxisBits;
  localparam int unsigned FR = obb_sat_pkg::AxisFrac;

  typedef logic signed [127:0] wide_t;

  logic [59:0] q_center, q_half;
  logic [47:0] q_axis [3];
  obb_sat_pkg::out_beat_t expected_q [$];

  function automatic wide_t mag128(wide_t x);
    return x < 0 ? -x : x;
  endfunction

  function automatic obb_sat_pkg::out_beat_t predict_overlap(obb_sat_pkg::in_beat_t nb);
    wide_t ca [3], cb [3], ea [3], eb [3], t [3], ta [3], tb [3];
    wide_t ax [3][3], bx [3][3], r [3][3];
    wide_t lhs, rhs;
    logic [47:0] na [3];
    int found, i1, i2, j1, j2;
    obb_sat_pkg::out_beat_t res;
    found = 0;
    na[0] = nb.node_axis_u;
    na[1] = nb.node_axis_v;
    na[2] = nb.node_axis_w;
    for (int k = 0; k < 3; k++) begin
      ca[k] = $signed(nb.node_center[k*CB +: CB]);
      cb[k] = $signed(q_center[k*CB +: CB]);
      ea[k] = {108'b0, nb.node_half_sizes[k*CB +: CB]};
      eb[k] = {108'b0, q_half[k*CB +: CB]};
      t[k]  = cb[k] - ca[k];
      for (int i = 0; i < 3; i++) begin
        ax[i][k] = $signed(na[i][k*AB +: AB]);
        bx[i][k] = $signed(q_axis[i][k*AB +: AB]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      ta[i] = t[0]*ax[i][0] + t[1]*ax[i][1] + t[2]*ax[i][2];
      tb[i] = t[0]*bx[i][0] + t[1]*bx[i][1] + t[2]*bx[i][2];
      for (int j = 0; j < 3; j++)
        r[i][j] = ax[i][0]*bx[j][0] + ax[i][1]*bx[j][1] + ax[i][2]*bx[j][2];
    end
    for (int i = 0; i < 3 && found == 0; i++) begin
      lhs = mag128(ta[i]) <<< FR;
      rhs = ea[i] <<< (2*FR);
      for (int j = 0; j < 3; j++) rhs = rhs + eb[j] * mag128(r[i][j]);
      if (lhs > rhs) found = 1 + i;
    end
    for (int j = 0; j < 3 && found == 0; j++) begin
      lhs = mag128(tb[j]) <<< FR;
      rhs = eb[j] <<< (2*FR);
      for (int i = 0; i < 3; i++) rhs = rhs + ea[i] * mag128(r[i][j]);
      if (lhs > rhs) found = 4 + j;
    end
    for (int i = 0; i < 3 && found == 0; i++) begin
      i1 = (i + 1) % 3;
      i2 = (i + 2) % 3;
      for (int j = 0; j < 3 && found == 0; j++) begin
        j1 = (j + 1) % 3;
        j2 = (j + 2) % 3;
        lhs = mag128(ta[i2]*r[i1][j] - ta[i1]*r[i2][j]);
        rhs = ea[i1]*mag128(r[i2][j]) + ea[i2]*mag128(r[i1][j])
            + eb[j1]*mag128(r[i][j2]) + eb[j2]*mag128(r[i][j1]);
        rhs = rhs <<< FR;
        if (lhs > rhs) found = 7 + 3*i + j;
      end
    end
    res.overlap = (found == 0);
    res.separating_axis = (found == 0) ? obb_sat_pkg::AxisNone : 4'(found);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    obb_sat_pkg::out_beat_t want;
    if (!rst_ni) begin
      q_center  <= '0;
      q_half    <= '0;
      q_axis[0] <= '0;
      q_axis[1] <= '0;
      q_axis[2] <= '0;
      errors_o  <= 0;
      checked_o <= 0;
      expected_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) expected_q = {expected_q, predict_overlap(in_data_i)};
      if (out_valid_i && !out_stall_i) begin
        checked_o <= checked_o + 1;
        if (expected_q.size() == 0) begin
          $display("%0t: result beat with none expected, actual %p", $time, out_data_i);
          errors_o <= errors_o + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.overlap !== out_data_i.overlap ||
              want.separating_axis !== out_data_i.separating_axis) begin
            $display("%0t: overlap/axis expected %0b/%0d actual %0b/%0d", $time,
                     want.overlap, want.separating_axis,
                     out_data_i.overlap, out_data_i.separating_axis);
            errors_o <= errors_o + 1;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          obb_sat_pkg::RegQCenter: q_center  <= cfg_data_i;
          obb_sat_pkg::RegQAxisU:  q_axis[0] <= cfg_data_i[47:0];
          obb_sat_pkg::RegQAxisV:  q_axis[1] <= cfg_data_i[47:0];
          obb_sat_pkg::RegQAxisW:  q_axis[2] <= cfg_data_i[47:0];
          obb_sat_pkg::RegQHalf:   q_half    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign pending_o = expected_q.size();
endmodule

@@ dv/tb_top.sv @@
// Testbench top for obb_separating_axis_test_core: clock, reset, query set-up,
// node box stimulus, output stalls and verdict. Depends on obb_sat_pkg and obb_sat_checker.
`timescale 1ns / 100ps
module tb_top;
  localparam int unsigned IW = obb_sat_pkg::CfgIdxBits;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [IW-1:0] cfg_idx = '0;
  logic [obb_sat_pkg::CfgBits-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  obb_sat_pkg::in_beat_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  obb_sat_pkg::out_beat_t out_data;
  int errors, pending, checked;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int sent = 0;

  always #5 clk = ~clk;

  obb_separating_axis_test_core dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .in_data_i(in_data), .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_data_o(out_data)
  );

  obb_sat_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_valid_i(in_valid), .in_stall_i(in_stall),
    .in_data_i(in_data), .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_data_i(out_data), .errors_o(errors), .pending_o(pending),
    .checked_o(checked)
  );

  function automatic logic [59:0] coords(int x, int y, int z);
    return {20'(z), 20'(y), 20'(x)};
  endfunction

  function automatic logic [47:0] axis3(int x, int y, int z);
    return {16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic logic [59:0] rand60();
    return 60'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic [47:0] rand_axis();
    if ($urandom_range(0, 7) == 0) return rand48();
    return axis3(int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384,
                 int'($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic obb_sat_pkg::in_beat_t rand_node();
    obb_sat_pkg::in_beat_t b;
    if ($urandom_range(0, 7) == 0) begin
      b.node_center = rand60();
      b.node_half_sizes = rand60();
    end else begin
      b.node_center = coords(int'($urandom_range(0, 16384)) - 8192,
                             int'($urandom_range(0, 16384)) - 8192,
                             int'($urandom_range(0, 16384)) - 8192);
      b.node_half_sizes = coords($urandom_range(0, 4096), $urandom_range(0, 4096),
                                 $urandom_range(0, 4096));
    end
    b.node_axis_u = rand_axis();
    b.node_axis_v = rand_axis();
    b.node_axis_w = rand_axis();
    return b;
  endfunction

  function automatic obb_sat_pkg::in_beat_t node(logic [59:0] c, logic [47:0] u,
                                                 logic [47:0] v, logic [47:0] w,
                                                 logic [59:0] h);
    obb_sat_pkg::in_beat_t b;
    b.node_center = c;
    b.node_axis_u = u;
    b.node_axis_v = v;
    b.node_axis_w = w;
    b.node_half_sizes = h;
    return b;
  endfunction

  task automatic write_reg(logic [IW-1:0] idx, logic [obb_sat_pkg::CfgBits-1:0] val);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_query(logic [59:0] c, logic [47:0] u, logic [47:0] v,
                           logic [47:0] w, logic [59:0] h);
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    write_reg(obb_sat_pkg::RegQCenter, c);
    write_reg(obb_sat_pkg::RegQAxisU, {12'b0, u});
    write_reg(obb_sat_pkg::RegQAxisV, {12'b0, v});
    write_reg(obb_sat_pkg::RegQAxisW, {12'b0, w});
    write_reg(obb_sat_pkg::RegQHalf, h);
    write_reg(IW'(5 + $urandom_range(0, 2)), rand60());
  endtask

  task automatic send_beat(obb_sat_pkg::in_beat_t b);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = b;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // receiver stalls
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_req = 1'b0;
      end
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall = 1'b1;
        n = $urandom_range(1, 13);
        repeat (n - 1) @(negedge clk);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  initial begin
    #50_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [47:0] ux, uy, uz;
    ux = axis3(16384, 0, 0);
    uy = axis3(0, 16384, 0);
    uz = axis3(0, 0, 16384);
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset query: zero box
    send_beat('0);
    send_beat(node(coords(5, 0, 0), ux, uy, uz, coords(1, 1, 1)));
    set_query('0, ux, uy, uz, coords(2560, 2560, 2560));
    send_beat('0);
    send_beat(node(coords(-5120, 0, 0), ux, uy, uz, coords(2560, 2560, 2560)));
    send_beat(node(coords(-5121, 0, 0), ux, uy, uz, coords(2560, 2560, 2560)));
    send_beat(node(coords(0, 5121, 0), ux, uy, uz, coords(2560, 2560, 2560)));
    send_beat(node(coords(0, 0, -5121), ux, uy, uz, coords(2560, 2560, 2560)));
    send_beat(node(coords(0, 0, 5120), ux, uy, uz, coords(2560, 2560, 2560)));
    send_beat(node(coords(3000, 3000, 0), axis3(11585, 11585, 0),
                   axis3(-11585, 11585, 0), uz, coords(256, 256, 256)));
    send_beat(node(coords(4000, 4000, 4000), axis3(9459, 9459, 9459),
                   axis3(-11585, 11585, 0), axis3(-6689, -6689, 13377),
                   coords(3000, 100, 100)));
    send_beat(node(coords(100, 200, 300), axis3(32767, 0, 0), axis3(0, 100, 0),
                   axis3(0, 0, -32768), coords(2560, 2560, 2560)));
    send_beat(node('1, '1, '1, '1, '1));
    send_beat(node(coords(-524288, -524288, -524288), axis3(-32768, -32768, -32768),
                   axis3(32767, 32767, 32767), axis3(-32768, 32767, 0), '1));
    send_beat(node(coords(524287, 524287, 524287), ux, uy, uz, '0));
    send_beat(node(coords(0, 0, 0), '0, '0, '0, '0));
    send_beat(node(coords(9000, 9000, 9000), axis3(11585, 0, 11585),
                   axis3(0, 16384, 0), axis3(-11585, 0, 11585), coords(2000, 2000, 10)));
    for (int i = 0; i < 5; i++) send_beat(rand_node());

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_query(coords(int'($urandom_range(0, 2048)) - 1024, 0, 0), rand_axis(),
                     rand_axis(), rand_axis(),
                     coords($urandom_range(0, 4096), $urandom_range(0, 4096),
                            $urandom_range(0, 4096)));
        1: set_query('1, '1, '1, '1, '1);
        2: set_query(rand60(), rand48(), rand48(), rand48(), rand60());
        default: set_query(coords(300, -200, 100), axis3(11585, 11585, 0),
                           axis3(-11585, 11585, 0), uz, coords(3000, 1500, 700));
      endcase
      for (int i = 0; i < 330; i++) begin
        if (ph == 0 && i == 100) hold_req = 1'b1;
        if (ph == 3 && i == 230) calm = 1'b1;
        send_beat(rand_node());
      end
    end

    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Sent %0d node boxes over six query boxes, checked %0d results", sent, checked);
    $display("Covered touching, parallel, non-unit and extreme boxes with stalls");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

@@ sim.f @@
sv/obb_sat_pkg.sv
sv/obb_sat_front.sv
sv/obb_sat_queue.sv
sv/obb_sat_back.sv
sv/obb_separating_axis_test_core.sv
dv/obb_sat_checker.sv
dv/tb_top.sv
